[src/multi_channel_heartbeat_watchdog_core_defines.svh]
// Assertion macros for the heartbeat watchdog core.
// No dependencies; included by the top level only.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_CORE_DEFINES_SVH

// same-cycle implication, gated off during reset
`define MCHW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, gated off during reset
`define MCHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/mchw_pkg.sv]
// Shared types and constants for the heartbeat watchdog core.
// No dependencies; used by mchw_cell and the top level.
package mchw_pkg;

    localparam int unsigned NUM_CHANNELS = 8;
    localparam int unsigned CHAN_SLOTS   = 8;
    localparam int unsigned NUM_CELLS    = (NUM_CHANNELS < CHAN_SLOTS) ? NUM_CHANNELS
                                                                        : CHAN_SLOTS;
    localparam int unsigned CNT_W        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    localparam int unsigned CHAN_W  = 3;
    localparam int unsigned SEQ_W   = 16;
    localparam int unsigned TYPE_W  = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TMO_W   = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd5;

    localparam logic OP_BEAT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_RECEIPT = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] channel;
        logic [SEQ_W-1:0]  seq_number;
        logic [TYPE_W-1:0] msg_type;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] chan_out;
        logic [SEQ_W-1:0]  seq_out;
        logic [TYPE_W-1:0] type_out;
        logic              gap_found;
        logic [SEQ_W-1:0]  gap_first;
        logic [SEQ_W-1:0]  gap_last;
        logic              last_of_run;
    } t_out;

    // scan token handed from cell to cell, carrying the new time
    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] now;
    } t_scan;

endpackage

[src/mchw_cell.sv]
// One channel cell: stored sequence, last beat stamp, timeout check.
// Depends on mchw_pkg. Passes the scan token to its neighbor each cycle.
module mchw_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [mchw_pkg::SEQ_W-1:0]    i_seq,
    input  logic [mchw_pkg::TIME_W-1:0]   i_now,
    input  logic [mchw_pkg::TMO_W-1:0]    i_timeout,
    input  mchw_pkg::t_scan               i_scan,
    output mchw_pkg::t_scan               o_scan,
    output logic [mchw_pkg::SEQ_W-1:0]    o_seq,
    output logic                          o_hit
);

    logic [mchw_pkg::SEQ_W-1:0]  r_seq,   n_seq;
    logic [mchw_pkg::TIME_W-1:0] r_stamp, n_stamp;
    mchw_pkg::t_scan             r_scan;
    logic [mchw_pkg::TIME_W-1:0] age;

    always_comb begin
        age     = i_scan.now - r_stamp;
        o_hit   = i_scan.active && (age > mchw_pkg::TIME_W'(i_timeout));
        n_seq   = r_seq;
        n_stamp = r_stamp;
        if (o_hit) begin
            // expired: restart the channel at the new time
            n_seq   = '0;
            n_stamp = i_scan.now;
        end else if (i_wr) begin
            n_seq   = i_seq;
            n_stamp = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_stamp <= '0;
            r_scan  <= '0;
        end else begin
            r_seq   <= n_seq;
            r_stamp <= n_stamp;
            r_scan  <= i_scan;
        end
    end

    assign o_scan = r_scan;
    assign o_seq  = r_seq;

endmodule

[src/multi_channel_heartbeat_watchdog_core.sv]
// Heartbeat watchdog over NUM_CELLS channels. A heartbeat word (start while busy is
// low) gives its receipt on o_res in the next cycle, with o_strobe high, and the next
// word may follow at once. A tick word holds busy high through the scan and flush
// states, so the next word is taken once busy drops: a scan token walks the
// row of channel cells, one cell per cycle, and each expired channel gives a timeout
// word in ascending channel order, the last one flagged last_of_run and shown in the
// first cycle after busy drops.
// The receiver cannot stall: every word on o_res is valid for one cycle only.
// Timeout register writes are taken whenever busy is low.
`include "multi_channel_heartbeat_watchdog_core_defines.svh"

module multi_channel_heartbeat_watchdog_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mchw_pkg::t_in                 i_cmd,
    output logic                          o_strobe,
    output mchw_pkg::t_out                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mchw_pkg::TMO_W-1:0]    i_cfg_data
);

    localparam int unsigned N = mchw_pkg::NUM_CELLS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [mchw_pkg::CNT_W-1:0]      r_cnt,   n_cnt;
    logic [mchw_pkg::TIME_W-1:0]     r_now,   n_now;
    logic [mchw_pkg::TMO_W-1:0]      r_timeout;
    mchw_pkg::t_scan                 r_launch, n_launch;
    logic                            r_pend_v, n_pend_v;
    mchw_pkg::t_out                  r_pend,   n_pend;
    logic                            r_strobe, n_strobe;
    mchw_pkg::t_out                  r_res,    n_res;

    mchw_pkg::t_scan                 chain [N+1];
    logic [mchw_pkg::SEQ_W-1:0]      cell_seq [N];
    logic [N-1:0]                    hits;
    logic [N-1:0]                    wr;

    logic                            accept;
    logic                            watched;
    logic [mchw_pkg::SEQ_W-1:0]      prev_seq;
    logic [mchw_pkg::SEQ_W:0]        prev_inc;
    logic                            gap;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign watched     = ((mchw_pkg::CHAN_W + 1)'(i_cmd.channel) <
                          (mchw_pkg::CHAN_W + 1)'(N));

    assign chain[0] = r_launch;

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign wr[g] = accept && (i_cmd.opcode == mchw_pkg::OP_BEAT) &&
                       (i_cmd.channel == mchw_pkg::CHAN_W'(g));
        mchw_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (wr[g]),
            .i_seq     (i_cmd.seq_number),
            .i_now     (r_now),
            .i_timeout (r_timeout),
            .i_scan    (chain[g]),
            .o_scan    (chain[g+1]),
            .o_seq     (cell_seq[g]),
            .o_hit     (hits[g])
        );
    end

    // previous sequence of the addressed channel
    always_comb begin
        prev_seq = '0;
        for (int unsigned k = 0; k < N; k++) begin
            if (i_cmd.channel == mchw_pkg::CHAN_W'(k)) begin
                prev_seq = cell_seq[k];
            end
        end
        prev_inc = {1'b0, prev_seq} + 1'b1;
        gap      = (prev_seq != '0) && ({1'b0, i_cmd.seq_number} > prev_inc);
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_now    = r_now;
        n_launch = '{active: 1'b0, now: r_now};
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_res    = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == mchw_pkg::OP_TICK) begin
                        n_now    = r_now + 1'b1;
                        n_launch = '{active: 1'b1, now: r_now + 1'b1};
                        n_cnt    = '0;
                        n_state  = ST_SCAN;
                    end else if (watched) begin
                        n_strobe          = 1'b1;
                        n_res.kind        = mchw_pkg::KIND_RECEIPT;
                        n_res.chan_out    = i_cmd.channel;
                        n_res.seq_out     = i_cmd.seq_number;
                        n_res.type_out    = i_cmd.msg_type;
                        n_res.gap_found   = gap;
                        n_res.gap_first   = gap ? prev_inc[mchw_pkg::SEQ_W-1:0] : '0;
                        n_res.gap_last    = gap ? (i_cmd.seq_number - 1'b1) : '0;
                        n_res.last_of_run = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // hold each timeout word in r_pend until the next one or the flush, so the final one can be flagged
                if (|hits) begin
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_res    = r_pend;
                    end
                    n_pend_v           = 1'b1;
                    n_pend             = '0;
                    n_pend.kind        = mchw_pkg::KIND_TIMEOUT;
                    n_pend.chan_out    = mchw_pkg::CHAN_W'(r_cnt);
                end
                if (r_cnt == mchw_pkg::CNT_W'(N - 1)) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_pend_v) begin
                    n_strobe          = 1'b1;
                    n_res             = r_pend;
                    n_res.last_of_run = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state  = ST_IDLE;
                n_pend_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_now     <= '0;
            r_timeout <= mchw_pkg::TIMEOUT_RESET;
            r_launch  <= '0;
            r_pend_v  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_now    <= n_now;
            r_launch <= n_launch;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    `MCHW_ASSERT_NOW(a_one_cell_hits, 1'b1, $onehot0(hits),
        "more than one cell expired at once")
    `MCHW_ASSERT_NOW(a_scan_exits_row, chain[N].active, r_state == ST_FLUSH,
        "scan token out of step with sequencer")
    `MCHW_ASSERT_NEXT(a_beat_receipt,
        accept && (i_cmd.opcode == mchw_pkg::OP_BEAT) && watched,
        o_strobe && (o_res.kind == mchw_pkg::KIND_RECEIPT) && o_res.last_of_run,
        "heartbeat receipt missing")
    `MCHW_ASSERT_NEXT(a_tick_starts, accept && (i_cmd.opcode == mchw_pkg::OP_TICK),
        busy && !o_strobe, "tick did not start a scan")

endmodule

[dv/multi_channel_heartbeat_watchdog_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for multi_channel_heartbeat_watchdog_core: directed and random heartbeat
// and tick traffic, each result word checked against an in-bench channel-table model.
// Depends on mchw_pkg and the core RTL.
module multi_channel_heartbeat_watchdog_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    // leave margin after a scan before idle-only actions
    localparam int DRAIN_CYCLES   = mchw_pkg::NUM_CELLS + 4;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    mchw_pkg::t_in               i_cmd;
    logic                        o_strobe;
    mchw_pkg::t_out              o_res;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [mchw_pkg::TMO_W-1:0]  i_cfg_data;

    multi_channel_heartbeat_watchdog_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // channel-table model
    logic [mchw_pkg::TIME_W-1:0] sec_count;
    logic [mchw_pkg::SEQ_W-1:0]  chan_seq   [mchw_pkg::CHAN_SLOTS];
    logic [mchw_pkg::TIME_W-1:0] chan_stamp [mchw_pkg::CHAN_SLOTS];
    logic [mchw_pkg::TMO_W-1:0]  allowed_age;
    mchw_pkg::t_out              due_words [$];

    // stimulus-side sequence tracking, independent of the model
    logic [mchw_pkg::SEQ_W-1:0]  seq_hint [mchw_pkg::CHAN_SLOTS];

    int mismatch_count;
    int beats_sent;
    int ticks_sent;
    int cfg_writes;
    int receipts_seen;
    int timeouts_seen;
    int gaps_seen;
    int quiet_stretch;
    int idle_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_channel_table();
        sec_count   = '0;
        allowed_age = mchw_pkg::TIMEOUT_RESET;
        for (int i = 0; i < mchw_pkg::CHAN_SLOTS; i++) begin
            chan_seq[i]   = '0;
            chan_stamp[i] = '0;
            seq_hint[i]   = '0;
        end
    endfunction

    // Work out the result words one accepted command word causes.
    function automatic void derive_watchdog_words(mchw_pkg::t_in w);
        mchw_pkg::t_out              r;
        mchw_pkg::t_out              tail;
        logic [mchw_pkg::SEQ_W-1:0]  prev;
        logic [mchw_pkg::TIME_W-1:0] age;
        int                          hits;
        hits = 0;
        if (w.opcode == mchw_pkg::OP_BEAT) begin
            if (w.channel < mchw_pkg::NUM_CELLS) begin
                prev       = chan_seq[w.channel];
                r          = '0;
                r.kind     = mchw_pkg::KIND_RECEIPT;
                r.chan_out = w.channel;
                r.seq_out  = w.seq_number;
                r.type_out = w.msg_type;
                // gap only when the old number was nonzero and we skipped past old+1
                if (prev != '0 && {1'b0, w.seq_number} > {1'b0, prev} + 17'd1) begin
                    r.gap_found = 1'b1;
                    r.gap_first = prev + 1'b1;
                    r.gap_last  = w.seq_number - 1'b1;
                end
                r.last_of_run = 1'b1;
                due_words.push_back(r);
                chan_seq[w.channel]   = w.seq_number;
                chan_stamp[w.channel] = sec_count;
            end
        end else begin
            sec_count = sec_count + 1'b1;
            for (int i = 0; i < mchw_pkg::NUM_CELLS; i++) begin
                age = sec_count - chan_stamp[i];
                if (age > {16'd0, allowed_age}) begin
                    r          = '0;
                    r.kind     = mchw_pkg::KIND_TIMEOUT;
                    r.chan_out = i[mchw_pkg::CHAN_W-1:0];
                    due_words.push_back(r);
                    chan_seq[i]   = '0;
                    chan_stamp[i] = sec_count;
                    hits++;
                end
            end
            if (hits > 0) begin
                tail = due_words.pop_back();
                tail.last_of_run = 1'b1;
                due_words.push_back(tail);
            end
        end
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
        $display("[%0t] MISMATCH %s: expected 'h%0h, got 'h%0h", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    task automatic check_word(mchw_pkg::t_out got);
        mchw_pkg::t_out want;
        if (due_words.size() == 0) begin
            flag_mismatch("word with nothing pending", 64'd0, 64'(got));
        end else begin
            want = due_words.pop_front();
            if (got.kind !== want.kind)
                flag_mismatch("kind", 64'(want.kind), 64'(got.kind));
            if (got.chan_out !== want.chan_out)
                flag_mismatch("chan_out", 64'(want.chan_out), 64'(got.chan_out));
            if (got.seq_out !== want.seq_out)
                flag_mismatch("seq_out", 64'(want.seq_out), 64'(got.seq_out));
            if (got.type_out !== want.type_out)
                flag_mismatch("type_out", 64'(want.type_out), 64'(got.type_out));
            if (got.gap_found !== want.gap_found)
                flag_mismatch("gap_found", 64'(want.gap_found), 64'(got.gap_found));
            if (got.gap_first !== want.gap_first)
                flag_mismatch("gap_first", 64'(want.gap_first), 64'(got.gap_first));
            if (got.gap_last !== want.gap_last)
                flag_mismatch("gap_last", 64'(want.gap_last), 64'(got.gap_last));
            if (got.last_of_run !== want.last_of_run)
                flag_mismatch("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
        end
        if (got.kind == mchw_pkg::KIND_TIMEOUT)
            timeouts_seen++;
        else
            receipts_seen++;
        if (got.gap_found)
            gaps_seen++;
    endtask

    // Check first, then predict: a word seen at this edge belongs to an earlier command.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                check_word(o_res);
            if (i_cfg_valid && o_cfg_ready) begin
                allowed_age = i_cfg_data;
                cfg_writes++;
            end
            if (start && !busy) begin
                if (i_cmd.opcode == mchw_pkg::OP_TICK)
                    ticks_sent++;
                else
                    beats_sent++;
                derive_watchdog_words(i_cmd);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (quiet_stretch > 0) begin
            quiet_stretch--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
            quiet_stretch = $urandom_range(30, 10);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_word(mchw_pkg::t_in w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_beat(int ch, logic [mchw_pkg::SEQ_W-1:0] seq,
                             logic [mchw_pkg::TYPE_W-1:0] typ);
        mchw_pkg::t_in w;
        w            = '0;
        w.opcode     = mchw_pkg::OP_BEAT;
        w.channel    = ch[mchw_pkg::CHAN_W-1:0];
        w.seq_number = seq;
        w.msg_type   = typ;
        send_word(w);
    endtask

    task automatic send_tick();
        mchw_pkg::t_in w;
        w        = '0;
        w.opcode = mchw_pkg::OP_TICK;
        send_word(w);
    endtask

    // Hold off the sender until every pending result word has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (due_words.size() != 0);
    endtask

    task automatic write_timeout(logic [mchw_pkg::TMO_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed per-channel sequences, with skips, repeats, rewinds and noise.
    task automatic pick_random_word(input int tick_pct, output mchw_pkg::t_in w);
        int                          roll;
        logic [mchw_pkg::CHAN_W-1:0] ch;
        logic [mchw_pkg::SEQ_W-1:0]  s;
        w = '0;
        w.channel    = mchw_pkg::CHAN_W'($urandom);
        w.seq_number = mchw_pkg::SEQ_W'($urandom);
        w.msg_type   = mchw_pkg::TYPE_W'($urandom);
        if ($urandom_range(99) < tick_pct) begin
            w.opcode = mchw_pkg::OP_TICK;
        end else begin
            ch   = w.channel;
            s    = seq_hint[ch];
            roll = $urandom_range(99);
            if (roll < 60)
                s = s + 1'b1;
            else if (roll < 75)
                s = s + mchw_pkg::SEQ_W'($urandom_range(60, 2));
            else if (roll < 82)
                s = s;
            else if (roll < 89)
                s = s - mchw_pkg::SEQ_W'($urandom_range(20, 1));
            else if (roll < 94)
                s = '0;
            else
                s = mchw_pkg::SEQ_W'($urandom);
            seq_hint[ch] = s;
            w.opcode     = mchw_pkg::OP_BEAT;
            w.seq_number = s;
        end
    endtask

    task automatic run_random(int count, int tick_pct);
        mchw_pkg::t_in w;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(24) == 0)
                wait_drained();
            pick_random_word(tick_pct, w);
            send_word(w);
        end
    endtask

    // Reset timeout of 5: gap rules, field extremes, then every channel expiring at once.
    task automatic test_directed();
        send_beat(0, 16'd0, 4'd0);
        send_beat(0, 16'd1, 4'd1);      // previous zero: never a gap
        send_beat(0, 16'd5, 4'd9);      // gap 2..4
        send_beat(0, 16'd5, 4'd2);      // repeat
        send_beat(0, 16'd3, 4'd3);      // going back
        send_beat(0, 16'd4, 4'd4);      // consecutive
        send_beat(7, 16'hFFFF, 4'hF);
        send_beat(7, 16'd1, 4'd10);
        send_beat(7, 16'hFFFF, 4'd5);   // widest gap
        send_beat(3, 16'h8000, 4'd10);
        send_beat(3, 16'd0, 4'd6);
        send_beat(3, 16'd2, 4'd7);
        send_beat(5, 16'h7FFF, 4'd8);
        repeat (5) send_tick();          // quiet ticks
        send_tick();                     // age 6 > 5 on all channels
        send_beat(0, 16'd7, 4'd1);       // sequence was cleared by the restart
        send_tick();
    endtask

    task automatic test_all_expire();
        write_timeout('0);
        run_random(30, 30);
    endtask

    task automatic test_never_expire();
        write_timeout('1);
        run_random(40, 40);
    endtask

    task automatic test_random_traffic();
        write_timeout(16'd1);
        run_random(45, 25);
        write_timeout(16'd2);
        run_random(45, 20);
        write_timeout(mchw_pkg::TMO_W'($urandom_range(12, 3)));
        run_random(45, 15);
        write_timeout(mchw_pkg::TMO_W'($urandom_range(6, 0)));
        run_random(45, 30);
    endtask

    task automatic test_end();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (due_words.size() != 0)
            flag_mismatch("result word never arrived", 64'(due_words.pop_front()), 64'd0);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        clear_channel_table();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_all_expire();
        test_never_expire();
        test_random_traffic();
        test_end();

        $display("Ran %0d heartbeats and %0d ticks across %0d timeout writes",
                 beats_sent, ticks_sent, cfg_writes);
        $display("Checked %0d receipts (%0d with a gap) and %0d timeouts; %0d mismatches",
                 receipts_seen, gaps_seen, timeouts_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
